[rtl/ihc_pkg.sv]
// ihc_pkg: shared types and constants for the IPv4 ingress header check.
// Used by every module of the block; depends on nothing.
package ihc_pkg;

    localparam logic [3:0]  VERSION_IPV4           = 4'd4;
    localparam logic [5:0]  HEADER_BYTES_MIN       = 6'd20;
    localparam logic [2:0]  IP4_DF                 = 3'b010;
    localparam logic [2:0]  IP4_MF                 = 3'b001;
    localparam logic [12:0] FRAG_OFFSET_MASK       = 13'h1FFF;
    localparam logic [31:0] ADDR_UNSPECIFIED       = 32'h0000_0000;
    localparam logic [31:0] ADDR_LIMITED_BROADCAST = 32'hFFFF_FFFF;

    localparam int          CFG_INDEX_W        = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_OWN_ADDRESS   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_OWN_BROADCAST = 2'd1;
    localparam logic [31:0] OWN_ADDRESS_RESET   = 32'h0000_0000;
    localparam logic [31:0] OWN_BROADCAST_RESET = 32'hFFFF_FFFF;

    typedef enum logic [3:0] {
        VERDICT_DELIVER      = 4'd0,
        VERDICT_BAD_VERSION  = 4'd1,
        VERDICT_SHORT_HEADER = 4'd2,
        VERDICT_BAD_CHECKSUM = 4'd3,
        VERDICT_TRUNCATED    = 4'd4,
        VERDICT_TTL_ZERO     = 4'd5,
        VERDICT_NOT_OURS     = 4'd6,
        VERDICT_FLAG_ERROR   = 4'd7,
        VERDICT_FRAGMENTED   = 4'd8
    } verdict_t;

    // One finished packet, handed from the front to the back.
    typedef struct packed {
        logic        early;        // fault found on the first halfword
        verdict_t    early_code;
        logic [5:0]  hbytes;
        logic [15:0] sum;
        logic [15:0] tlen;
        logic [15:0] id;
        logic [15:0] frag;
        logic [15:0] ttl_proto;
        logic [31:0] src;
        logic [31:0] dst;
        logic [15:0] flen;
    } rec_t;

    typedef struct packed {
        logic full;
        logic not_empty;
    } q_status_t;

endpackage

[rtl/ihc_front.sv]
// ihc_front: takes halfword beats, captures header fields, folds the checksum.
// Pushes one rec_t per packet into the queue. Depends on ihc_pkg.
module ihc_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               start_req,
    input  logic [15:0]        halfword,
    input  logic [15:0]        frame_bytes,
    input  ihc_pkg::q_status_t q_status,
    output logic               push,
    output ihc_pkg::rec_t      push_rec
);

    logic [4:0]  idx_reg,    idx_next;
    logic [4:0]  exp_reg,    exp_next;
    logic        done_reg,   done_next;
    logic [15:0] sum_reg,    sum_next;
    logic [63:0] fields_reg, fields_next;
    logic [63:0] addr_reg,   addr_next;
    logic [15:0] flen_reg,   flen_next;

    logic        accept;
    logic        active;
    logic [4:0]  base_idx;
    logic [15:0] base_sum;
    logic [16:0] sum_wide;
    logic [3:0]  ver;
    logic [3:0]  ihl;
    logic        early_bad;
    logic        finish;

    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;
    assign active   = accept && (start_req || !done_reg);
    assign ver      = halfword[15:12];
    assign ihl      = halfword[11:8];

    always_comb
    begin
        base_idx    = start_req ? 5'd0  : idx_reg;
        base_sum    = start_req ? 16'd0 : sum_reg;
        fields_next = start_req ? 64'd0 : fields_reg;
        addr_next   = start_req ? 64'd0 : addr_reg;
        flen_next   = start_req ? frame_bytes : flen_reg;
        exp_next    = start_req ? {ihl, 1'b0} : exp_reg;

        // end-around carry; the fold cannot overflow again
        sum_wide = {1'b0, base_sum} + {1'b0, halfword};
        sum_next = sum_wide[15:0] + {15'd0, sum_wide[16]};

        early_bad = start_req && ((ver != ihc_pkg::VERSION_IPV4) ||
                                  ({ihl, 2'b00} < ihc_pkg::HEADER_BYTES_MIN));

        case (base_idx)
            5'd1: fields_next[15:0]  = halfword;
            5'd2: fields_next[31:16] = halfword;
            5'd3: fields_next[47:32] = halfword;
            5'd4: fields_next[63:48] = halfword;
            5'd6: addr_next[63:48]   = halfword;
            5'd7: addr_next[47:32]   = halfword;
            5'd8: addr_next[31:16]   = halfword;
            5'd9: addr_next[15:0]    = halfword;
            default: ;
        endcase

        idx_next  = base_idx + 5'd1;
        finish    = active && (early_bad || (idx_next >= exp_next));
        done_next = finish;

        push_rec.early      = early_bad;
        push_rec.early_code = (ver != ihc_pkg::VERSION_IPV4) ? ihc_pkg::VERDICT_BAD_VERSION
                                                             : ihc_pkg::VERDICT_SHORT_HEADER;
        push_rec.hbytes     = start_req ? {ihl, 2'b00} : {exp_reg, 1'b0};
        push_rec.sum        = sum_next;
        push_rec.tlen       = fields_next[15:0];
        push_rec.id         = fields_next[31:16];
        push_rec.frag       = fields_next[47:32];
        push_rec.ttl_proto  = fields_next[63:48];
        push_rec.src        = addr_next[63:32];
        push_rec.dst        = addr_next[31:0];
        push_rec.flen       = flen_next;
    end

    assign push = finish;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= 5'd0;
            exp_reg  <= 5'd0;
            done_reg <= 1'b1;
        end
        else if (active)
        begin
            idx_reg  <= idx_next;
            exp_reg  <= exp_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (active)
        begin
            sum_reg    <= sum_next;
            fields_reg <= fields_next;
            addr_reg   <= addr_next;
            flen_reg   <= flen_next;
        end
    end

endmodule

[rtl/ihc_queue.sv]
// ihc_queue: short FIFO of finished packet records between front and back.
// Depends on ihc_pkg for rec_t and q_status_t.
module ihc_queue
#(
    parameter int DEPTH = 2
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  ihc_pkg::rec_t      push_rec,
    input  logic               pop,
    output ihc_pkg::rec_t      head,
    output ihc_pkg::q_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULLC = CNT_W'(DEPTH);

    ihc_pkg::rec_t    entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign head             = entry_reg[rd_reg];
    assign status.full      = (cnt_reg == FULLC);
    assign status.not_empty = (cnt_reg != '0);

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wr_next = (wr_reg == LAST) ? '0 : wr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_next = (rd_reg == LAST) ? '0 : rd_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_reg] <= push_rec;
        end
    end

endmodule

[rtl/ihc_back.sv]
// ihc_back: turns a packet record into a verdict and holds the result beat.
// Depends on ihc_pkg; takes the own addresses from the top level.
module ihc_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  ihc_pkg::rec_t      head,
    input  ihc_pkg::q_status_t q_status,
    output logic               pop,
    input  logic [31:0]        own_address,
    input  logic [31:0]        own_broadcast,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [3:0]         verdict,
    output logic               length_mismatch,
    output logic [5:0]         header_bytes,
    output logic [7:0]         protocol,
    output logic [31:0]        source_address,
    output logic [31:0]        destination_address,
    output logic [15:0]        packet_id,
    output logic [15:0]        total_length
);

    logic              valid_reg;
    ihc_pkg::verdict_t verdict_reg, verdict_next;
    logic              mis_reg, mis_next;
    logic [5:0]        hb_reg;
    logic [7:0]        proto_reg;
    logic [31:0]       src_reg, dst_reg;
    logic [15:0]       id_reg, tlen_reg;

    logic [2:0]  flags;
    logic        ours;

    assign pop   = q_status.not_empty && (!valid_reg || out_ready);
    assign flags = head.frag[15:13];
    assign ours  = (head.dst == ihc_pkg::ADDR_UNSPECIFIED)       ||
                   (head.dst == ihc_pkg::ADDR_LIMITED_BROADCAST) ||
                   (head.dst == own_address)                     ||
                   (head.dst == own_broadcast);

    always_comb
    begin
        mis_next = !head.early && (head.tlen != head.flen);
        if (head.early)
            verdict_next = head.early_code;
        else if (head.sum != 16'hFFFF)
            verdict_next = ihc_pkg::VERDICT_BAD_CHECKSUM;
        else if (head.tlen > head.flen)
            verdict_next = ihc_pkg::VERDICT_TRUNCATED;
        else if (head.ttl_proto[15:8] == 8'd0)
            verdict_next = ihc_pkg::VERDICT_TTL_ZERO;
        else if (!ours)
            verdict_next = ihc_pkg::VERDICT_NOT_OURS;
        else if ((flags & (ihc_pkg::IP4_DF | ihc_pkg::IP4_MF)) ==
                 (ihc_pkg::IP4_DF | ihc_pkg::IP4_MF))
            verdict_next = ihc_pkg::VERDICT_FLAG_ERROR;
        else if (((flags & ihc_pkg::IP4_MF) != 3'd0) ||
                 ((head.frag[12:0] & ihc_pkg::FRAG_OFFSET_MASK) != 13'd0))
            verdict_next = ihc_pkg::VERDICT_FRAGMENTED;
        else
            verdict_next = ihc_pkg::VERDICT_DELIVER;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            verdict_reg <= verdict_next;
            mis_reg     <= mis_next;
            hb_reg      <= head.hbytes;
            proto_reg   <= head.ttl_proto[7:0];
            src_reg     <= head.src;
            dst_reg     <= head.dst;
            id_reg      <= head.id;
            tlen_reg    <= head.tlen;
        end
    end

    assign out_valid           = valid_reg;
    assign verdict             = verdict_reg;
    assign length_mismatch     = mis_reg;
    assign header_bytes        = hb_reg;
    assign protocol            = proto_reg;
    assign source_address      = src_reg;
    assign destination_address = dst_reg;
    assign packet_id           = id_reg;
    assign total_length        = tlen_reg;

endmodule

[rtl/ipv4_ingress_header_check.sv]
// ipv4_ingress_header_check: top level of the IPv4 receive header checker.
// Instantiates ihc_front, ihc_queue and ihc_back; depends on ihc_pkg.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  in       | in_valid / in_ready  | start_req, halfword, frame_bytes
//  out      | out_valid/ out_ready | verdict, length_mismatch, header_bytes,
//           |                      | protocol, source/destination_address,
//           |                      | packet_id, total_length
//  cfg      | cfg_write            | cfg_index, cfg_data
//
// One halfword beat per cycle while in_ready is high. After a packet's last header halfword
// the front pushes its record into the queue, and the back registers the verdict beat.
// The front takes beats while the record queue has room; the queue and the back's
// output register let a stalled out side hold up to QUEUE_DEPTH + 1 verdicts.
// Reset acts on control and configuration only; own_address resets to 0, own_broadcast to all ones.
module ipv4_ingress_header_check
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    // input beats
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        start_req,
    input  logic [15:0] halfword,
    input  logic [15:0] frame_bytes,
    // verdict beats
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  verdict,
    output logic        length_mismatch,
    output logic [5:0]  header_bytes,
    output logic [7:0]  protocol,
    output logic [31:0] source_address,
    output logic [31:0] destination_address,
    output logic [15:0] packet_id,
    output logic [15:0] total_length,
    // configuration writes
    input  logic        cfg_write,
    input  logic [ihc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0] cfg_data
);

    logic [31:0] own_address_reg;
    logic [31:0] own_broadcast_reg;

    logic               push;
    logic               pop;
    ihc_pkg::rec_t      push_rec;
    ihc_pkg::rec_t      head;
    ihc_pkg::q_status_t q_status;

    // Writes to indexes beyond the register list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_address_reg   <= ihc_pkg::OWN_ADDRESS_RESET;
            own_broadcast_reg <= ihc_pkg::OWN_BROADCAST_RESET;
        end
        else if (cfg_write)
        begin
            if (cfg_index == ihc_pkg::REG_OWN_ADDRESS)
                own_address_reg <= cfg_data;
            else if (cfg_index == ihc_pkg::REG_OWN_BROADCAST)
                own_broadcast_reg <= cfg_data;
        end
    end

    // Front: header capture, checksum fold, early version/length faults.
    ihc_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .start_req   (start_req),
        .halfword    (halfword),
        .frame_bytes (frame_bytes),
        .q_status    (q_status),
        .push        (push),
        .push_rec    (push_rec)
    );

    ihc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    // Back: priority verdict and the output beat register.
    ihc_back u_back
    (
        .clk                 (clk),
        .rst_n               (rst_n),
        .head                (head),
        .q_status            (q_status),
        .pop                 (pop),
        .own_address         (own_address_reg),
        .own_broadcast       (own_broadcast_reg),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .verdict             (verdict),
        .length_mismatch     (length_mismatch),
        .header_bytes        (header_bytes),
        .protocol            (protocol),
        .source_address      (source_address),
        .destination_address (destination_address),
        .packet_id           (packet_id),
        .total_length        (total_length)
    );

endmodule
